@@ hdl/tmec_pkg.sv @@
// ---------------------------------------------------------------------------
// tmec_pkg
// Shared constants, types and helpers of the exact-pixel template matcher.
// ---------------------------------------------------------------------------
package tmec_pkg;

  localparam int MAX_SCENE_ROWS = 1024;
  localparam int MAX_SCENE_COLS = 1024;
  localparam int MAX_TPL_ROWS   = 64;
  localparam int MAX_TPL_COLS   = 64;

  localparam int PIX_W     = 8;
  localparam int DIM_W     = 11;
  localparam int TDIM_W    = 7;
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 2;
  localparam int ROW_W     = 10;
  localparam int COL_W     = 10;
  localparam int SCORE_W   = 13;

  localparam int SCENE_DEPTH = MAX_SCENE_ROWS * MAX_SCENE_COLS;
  localparam int TPL_DEPTH   = MAX_TPL_ROWS * MAX_TPL_COLS;
  localparam int SADDR_W     = $clog2(SCENE_DEPTH);
  localparam int TADDR_W     = $clog2(TPL_DEPTH);
  localparam int SCNT_W      = SADDR_W + 1;
  localparam int TCNT_W      = TADDR_W + 1;
  localparam int TY_W        = (MAX_TPL_ROWS > 1) ? $clog2(MAX_TPL_ROWS) : 1;
  localparam int TX_W        = (MAX_TPL_COLS > 1) ? $clog2(MAX_TPL_COLS) : 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCENE_ROWS = 2'd0,
    REG_SCENE_COLS = 2'd1,
    REG_TPL_ROWS   = 2'd2,
    REG_TPL_COLS   = 2'd3
  } reg_idx_t;

  typedef enum logic {
    FUNC_TPL   = 1'b0,
    FUNC_SCENE = 1'b1
  } func_t;

  typedef struct packed {
    logic [DIM_W-1:0]  sr;
    logic [DIM_W-1:0]  sc;
    logic [TDIM_W-1:0] tr;
    logic [TDIM_W-1:0] tc;
  } dims_t;

  typedef struct packed {
    logic             valid;
    logic             last;
    logic             fin;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } tag_t;

  typedef struct packed {
    tag_t               tag;
    logic [SADDR_W-1:0] saddr;
    logic [TADDR_W-1:0] taddr;
  } issue_t;

  typedef struct packed {
    tag_t             tag;
    logic [PIX_W-1:0] spix;
    logic [PIX_W-1:0] tpix;
  } rd_t;

  typedef struct packed {
    logic [ROW_W-1:0]   row;
    logic [COL_W-1:0]   col;
    logic [SCORE_W-1:0] score;
  } result_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] maxv);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > maxv) begin
      r = maxv;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

@@ hdl/tmec_if.sv @@
// ---------------------------------------------------------------------------
// tmec_if
// Valid/ready channels of the matcher: pixel input and match result output.
// ---------------------------------------------------------------------------
interface tmec_in_if;
  import tmec_pkg::*;
  logic             valid;
  logic             ready;
  logic             func;
  logic [PIX_W-1:0] pixel;
  modport source (output valid, func, pixel, input ready);
  modport sink   (input valid, func, pixel, output ready);
endinterface

interface tmec_out_if;
  import tmec_pkg::*;
  logic               valid;
  logic               ready;
  logic [ROW_W-1:0]   best_row;
  logic [COL_W-1:0]   best_col;
  logic [SCORE_W-1:0] best_score;
  modport source (output valid, best_row, best_col, best_score, input ready);
  modport sink   (input valid, best_row, best_col, best_score, output ready);
endinterface

@@ hdl/tmec_seq.sv @@
// ---------------------------------------------------------------------------
// tmec_seq
// Placement sequencer: walks every in-image placement and every template
// pixel, one pixel pair per cycle, with incremental address arithmetic.
// ---------------------------------------------------------------------------
module tmec_seq (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  tmec_pkg::dims_t dims,
  output tmec_pkg::issue_t issue,
  output logic            idle
);
  import tmec_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_EMPTY} state_t;
  state_t state;

  logic [ROW_W-1:0]   r;
  logic [COL_W-1:0]   c;
  logic [TY_W-1:0]    y;
  logic [TX_W-1:0]    x;
  logic [SADDR_W-1:0] row_base;
  logic [SADDR_W-1:0] place_base;
  logic [SADDR_W-1:0] line_base;
  logic [SADDR_W-1:0] saddr;
  logic [TADDR_W-1:0] taddr;

  logic [TY_W-1:0]    tr_m1;
  logic [TX_W-1:0]    tc_m1;
  logic [ROW_W-1:0]   rlast;
  logic [COL_W-1:0]   clast;
  logic [SADDR_W-1:0] sc_ext;
  logic               fits, x_end, y_end, c_end, r_end;
  logic [SADDR_W-1:0] line_next, place_next, row_next;

  assign tr_m1  = TY_W'(dims.tr - TDIM_W'(1));
  assign tc_m1  = TX_W'(dims.tc - TDIM_W'(1));
  assign rlast  = ROW_W'(dims.sr - DIM_W'(dims.tr));
  assign clast  = COL_W'(dims.sc - DIM_W'(dims.tc));
  assign sc_ext = SADDR_W'(dims.sc);
  assign fits   = (DIM_W'(dims.tr) <= dims.sr) && (DIM_W'(dims.tc) <= dims.sc);
  assign x_end  = (x == tc_m1);
  assign y_end  = (y == tr_m1);
  assign c_end  = (c == clast);
  assign r_end  = (r == rlast);

  assign line_next  = line_base + sc_ext;
  assign place_next = place_base + SADDR_W'(1);
  assign row_next   = row_base + sc_ext;

  assign issue.tag.valid = (state != S_IDLE);
  assign issue.tag.last  = (state == S_RUN) && x_end && y_end;
  assign issue.tag.fin   = (state == S_EMPTY) ||
                           ((state == S_RUN) && x_end && y_end && c_end && r_end);
  assign issue.tag.row   = r;
  assign issue.tag.col   = c;
  assign issue.saddr     = saddr;
  assign issue.taddr     = taddr;
  assign idle            = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            r          <= '0;
            c          <= '0;
            y          <= '0;
            x          <= '0;
            row_base   <= '0;
            place_base <= '0;
            line_base  <= '0;
            saddr      <= '0;
            taddr      <= '0;
            state      <= fits ? S_RUN : S_EMPTY;
          end
        end
        S_EMPTY: begin
          r     <= '0;
          c     <= '0;
          state <= S_IDLE;
        end
        S_RUN: begin
          if (!x_end) begin
            x     <= x + TX_W'(1);
            saddr <= saddr + SADDR_W'(1);
            taddr <= taddr + TADDR_W'(1);
          end else if (!y_end) begin
            x         <= '0;
            y         <= y + TY_W'(1);
            line_base <= line_next;
            saddr     <= line_next;
            taddr     <= taddr + TADDR_W'(1);
          end else if (!c_end) begin
            x          <= '0;
            y          <= '0;
            c          <= c + COL_W'(1);
            place_base <= place_next;
            line_base  <= place_next;
            saddr      <= place_next;
            taddr      <= '0;
          end else if (!r_end) begin
            x          <= '0;
            y          <= '0;
            c          <= '0;
            r          <= r + ROW_W'(1);
            row_base   <= row_next;
            place_base <= row_next;
            line_base  <= row_next;
            saddr      <= row_next;
            taddr      <= '0;
          end else begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ hdl/tmec_store.sv @@
// ---------------------------------------------------------------------------
// tmec_store
// Template and scene image memories: one write and one registered read port
// each; the placement tag travels alongside the read data.
// ---------------------------------------------------------------------------
module tmec_store (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          t_we,
  input  logic [tmec_pkg::TADDR_W-1:0]  t_waddr,
  input  logic                          s_we,
  input  logic [tmec_pkg::SADDR_W-1:0]  s_waddr,
  input  logic [tmec_pkg::PIX_W-1:0]    wdata,
  input  tmec_pkg::issue_t              issue,
  output tmec_pkg::rd_t                 rd
);
  import tmec_pkg::*;

  logic [PIX_W-1:0] tpl_mem   [TPL_DEPTH];
  logic [PIX_W-1:0] scene_mem [SCENE_DEPTH];

  always_ff @(posedge clk) begin
    if (t_we) begin
      tpl_mem[t_waddr] <= wdata;
    end
    rd.tpix <= tpl_mem[issue.taddr];
  end

  always_ff @(posedge clk) begin
    if (s_we) begin
      scene_mem[s_waddr] <= wdata;
    end
    rd.spix <= scene_mem[issue.saddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd.tag.valid <= 1'b0;
    end else begin
      rd.tag.valid <= issue.tag.valid;
    end
    rd.tag.last <= issue.tag.last;
    rd.tag.fin  <= issue.tag.fin;
    rd.tag.row  <= issue.tag.row;
    rd.tag.col  <= issue.tag.col;
  end

endmodule

@@ hdl/tmec_score.sv @@
// ---------------------------------------------------------------------------
// tmec_score
// Shared compare/count unit: counts equal pixel pairs per placement and
// keeps the first placement with the strictly highest count.
// ---------------------------------------------------------------------------
module tmec_score (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  tmec_pkg::rd_t     rd,
  output tmec_pkg::result_t res,
  output logic              done
);
  import tmec_pkg::*;

  logic [SCORE_W-1:0] hits;
  logic [SCORE_W-1:0] sum;
  logic               better;

  assign sum    = hits + SCORE_W'(rd.spix == rd.tpix);
  assign better = rd.tag.last && (sum > res.score);

  always_ff @(posedge clk) begin
    if (rst) begin
      done      <= 1'b0;
      hits      <= '0;
      res       <= '0;
    end else if (start) begin
      done      <= 1'b0;
      hits      <= '0;
      res       <= '0;
    end else begin
      done <= rd.tag.valid && rd.tag.fin;
      if (rd.tag.valid) begin
        hits <= rd.tag.last ? '0 : sum;
        if (better) begin
          res.score <= sum;
          res.row   <= rd.tag.row;
          res.col   <= rd.tag.col;
        end
      end
    end
  end

endmodule

@@ hdl/template_match_equal_count_top.sv @@
// ---------------------------------------------------------------------------
// template_match_equal_count_top
// Exact-pixel-count template matcher over stored template and scene images.
// ---------------------------------------------------------------------------
// Usage: write scene_rows/scene_cols/tpl_rows/tpl_cols on the cfg port while
// idle. Then send template pixels (func=0) and scene pixels (func=1) in raster
// order on in_ch, one transaction per cycle. Template pixels past the template
// size are dropped. The scene pixel that completes the scene starts scoring;
// in_ch.ready stays low until the result is placed in the output register.
// Scoring uses one compare/count unit fed by the two image memories, one
// template/scene pixel pair per cycle. The single result on out_ch holds
// best row, column and score (0,0,0 when nothing matches) until taken; new
// pixels are accepted while it waits, and a further result waits in the
// scorer if out_ch is still stalled. Reset (rst, synchronous) restores the
// default sizes and clears the pixel counters; image memory contents are
// not cleared.
// ---------------------------------------------------------------------------
module template_match_equal_count_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [tmec_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [tmec_pkg::CFG_W-1:0]     cfg_data,
  tmec_in_if.sink                        in_ch,
  tmec_out_if.source                     out_ch
);
  import tmec_pkg::*;

  typedef enum logic [1:0] {ST_LOAD, ST_SCORE, ST_PUSH} state_t;
  state_t state;

  logic [DIM_W-1:0]  scene_rows, scene_cols;
  logic [TDIM_W-1:0] tpl_rows, tpl_cols;
  dims_t             dims;

  logic [TCNT_W-1:0] tcount;
  logic [SCNT_W-1:0] scount;
  logic [TCNT_W-1:0] tsize;
  logic [SCNT_W-1:0] ssize;
  logic [SCNT_W-1:0] scount_inc;

  logic    accept, t_we, s_we, trigger, start, seq_idle, done;
  logic    out_valid;
  result_t out_res, res;
  issue_t  issue;
  rd_t     rd;

  always_ff @(posedge clk) begin
    if (rst) begin
      scene_rows <= DIM_W'(768);
      scene_cols <= DIM_W'(1024);
      tpl_rows   <= TDIM_W'(49);
      tpl_cols   <= TDIM_W'(36);
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_idx))
        REG_SCENE_ROWS: scene_rows <= cfg_data;
        REG_SCENE_COLS: scene_cols <= cfg_data;
        REG_TPL_ROWS:   tpl_rows   <= TDIM_W'(cfg_data);
        REG_TPL_COLS:   tpl_cols   <= TDIM_W'(cfg_data);
        default: ;
      endcase
    end
  end

  assign dims.sr = clamp_dim(scene_rows, DIM_W'(MAX_SCENE_ROWS));
  assign dims.sc = clamp_dim(scene_cols, DIM_W'(MAX_SCENE_COLS));
  assign dims.tr = TDIM_W'(clamp_dim(DIM_W'(tpl_rows), DIM_W'(MAX_TPL_ROWS)));
  assign dims.tc = TDIM_W'(clamp_dim(DIM_W'(tpl_cols), DIM_W'(MAX_TPL_COLS)));

  assign tsize      = TCNT_W'(dims.tr) * TCNT_W'(dims.tc);
  assign ssize      = SCNT_W'(dims.sr) * SCNT_W'(dims.sc);
  assign scount_inc = scount + SCNT_W'(1);

  assign in_ch.ready = (state == ST_LOAD);
  assign accept      = in_ch.valid && in_ch.ready;
  assign t_we        = accept && (func_t'(in_ch.func) == FUNC_TPL) && (tcount < tsize);
  assign s_we        = accept && (func_t'(in_ch.func) == FUNC_SCENE);
  assign trigger     = s_we && (scount_inc >= ssize);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_LOAD;
      tcount    <= '0;
      scount    <= '0;
      start     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      start <= 1'b0;
      if (out_valid && out_ch.ready && (state != ST_PUSH)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_LOAD: begin
          if (t_we) begin
            tcount <= tcount + TCNT_W'(1);
          end
          if (trigger) begin
            tcount <= '0;
            scount <= '0;
            start  <= 1'b1;
            state  <= ST_SCORE;
          end else if (s_we) begin
            scount <= scount_inc;
          end
        end
        ST_SCORE: begin
          if (done) begin
            state <= ST_PUSH;
          end
        end
        ST_PUSH: begin
          if (!out_valid || out_ch.ready) begin
            out_res   <= res;
            out_valid <= 1'b1;
            state     <= ST_LOAD;
          end
        end
        default: state <= ST_LOAD;
      endcase
    end
  end

  assign out_ch.valid      = out_valid;
  assign out_ch.best_row   = out_res.row;
  assign out_ch.best_col   = out_res.col;
  assign out_ch.best_score = out_res.score;

  tmec_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .dims  (dims),
    .issue (issue),
    .idle  (seq_idle)
  );

  tmec_store u_store (
    .clk     (clk),
    .rst     (rst),
    .t_we    (t_we),
    .t_waddr (tcount[TADDR_W-1:0]),
    .s_we    (s_we),
    .s_waddr (scount[SADDR_W-1:0]),
    .wdata   (in_ch.pixel),
    .issue   (issue),
    .rd      (rd)
  );

  tmec_score u_score (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .rd    (rd),
    .res   (res),
    .done  (done)
  );

  a_done_in_score: assert property (@(posedge clk) disable iff (rst)
    done |-> (state == ST_SCORE))
    else $error("scorer finished outside the scoring phase");

  a_start_seq_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> seq_idle)
    else $error("scoring started while the sequencer was busy");

  a_no_issue_in_load: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LOAD) |-> !issue.tag.valid)
    else $error("memory reads issued while pixels are being loaded");

  a_scene_count_range: assert property (@(posedge clk) disable iff (rst)
    !scount[SCNT_W-1])
    else $error("scene pixel counter ran past the memory depth");

endmodule

@@ verif/tb_template_match_equal_count_top.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_template_match_equal_count_top
// Self-checking bench for the exact-pixel-count template matcher.
// Loads template and scene images over the pixel channel with random gaps and
// a stalling result channel. A shadow copy of both images scores every
// in-scene placement and predicts best row, column and score for each
// completed scene. Covers size extremes, out-of-range sizes, oversized
// templates, dropped extra template pixels and a scene shrunk mid-load.
// ---------------------------------------------------------------------------
module tb_template_match_equal_count_top;
  import tmec_pkg::*;

  class tmatch_scoreboard;
    logic [CFG_W-1:0] size_regs [4];
    byte unsigned     tpl_px [TPL_DEPTH];
    byte unsigned     scene_px [SCENE_DEPTH];
    int unsigned      tpl_count;
    int unsigned      scene_count;
    result_t          best_match_q [$];
    int               fails;

    function new();
      size_regs[REG_SCENE_ROWS] = CFG_W'(768);
      size_regs[REG_SCENE_COLS] = CFG_W'(1024);
      size_regs[REG_TPL_ROWS]   = CFG_W'(49);
      size_regs[REG_TPL_COLS]   = CFG_W'(36);
      tpl_count   = 0;
      scene_count = 0;
      fails       = 0;
    endfunction

    function int unsigned fit_dim(logic [CFG_W-1:0] v, int unsigned hi);
      if (v == 0) return 1;
      if (v > hi) return hi;
      return 32'(v);
    endfunction

    function void used_dims(output int unsigned sr, output int unsigned sc,
                            output int unsigned tr, output int unsigned tc);
      sr = fit_dim(size_regs[REG_SCENE_ROWS], MAX_SCENE_ROWS);
      sc = fit_dim(size_regs[REG_SCENE_COLS], MAX_SCENE_COLS);
      tr = fit_dim(size_regs[REG_TPL_ROWS], MAX_TPL_ROWS);
      tc = fit_dim(size_regs[REG_TPL_COLS], MAX_TPL_COLS);
    endfunction

    function void write_reg(reg_idx_t idx, logic [CFG_W-1:0] v);
      if (idx == REG_TPL_ROWS || idx == REG_TPL_COLS) begin
        size_regs[idx] = v & 11'h07F;
      end else begin
        size_regs[idx] = v;
      end
    endfunction

    function result_t score_placements(int unsigned sr, int unsigned sc,
                                       int unsigned tr, int unsigned tc);
      result_t     best;
      int unsigned hits;
      int unsigned top;
      best = '0;
      top  = 0;
      if (tr <= sr && tc <= sc) begin
        for (int unsigned r = 0; r + tr <= sr; r++) begin
          for (int unsigned c = 0; c + tc <= sc; c++) begin
            hits = 0;
            for (int unsigned y = 0; y < tr; y++) begin
              for (int unsigned x = 0; x < tc; x++) begin
                if (scene_px[(r + y) * sc + c + x] == tpl_px[y * tc + x]) hits++;
              end
            end
            if (hits > top) begin
              top        = hits;
              best.row   = ROW_W'(r);
              best.col   = COL_W'(c);
              best.score = SCORE_W'(top);
            end
          end
        end
      end
      return best;
    endfunction

    function void note_input(func_t f, logic [PIX_W-1:0] p);
      int unsigned sr, sc, tr, tc;
      used_dims(sr, sc, tr, tc);
      if (f == FUNC_TPL) begin
        if (tpl_count < tr * tc) begin
          tpl_px[tpl_count] = p;
          tpl_count++;
        end
      end else begin
        if (scene_count < SCENE_DEPTH) scene_px[scene_count] = p;
        scene_count++;
        if (scene_count >= sr * sc) begin
          best_match_q.push_back(score_placements(sr, sc, tr, tc));
          tpl_count   = 0;
          scene_count = 0;
        end
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (best_match_q.size() == 0) begin
        fails++;
        if (fails <= 10)
          $display("unexpected result: row %0d col %0d score %0d",
                   got.row, got.col, got.score);
        return;
      end
      want = best_match_q.pop_front();
      if (got.row != want.row || got.col != want.col || got.score != want.score) begin
        fails++;
        if (fails <= 10)
          $display("result mismatch: expected row %0d col %0d score %0d,",
                   want.row, want.col, want.score,
                   " got row %0d col %0d score %0d",
                   got.row, got.col, got.score);
      end
    endfunction

    function int outstanding();
      return best_match_q.size();
    endfunction
  endclass

  localparam int CYCLE_LIMIT = 3_000_000;

  logic             clk;
  logic             rst;
  logic             cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0] cfg_data;

  tmec_in_if  in_ch ();
  tmec_out_if out_ch ();

  template_match_equal_count_top i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  tmatch_scoreboard sb;
  bit               tpl_loaded [TPL_DEPTH];
  bit               no_gaps;
  int               pixels_sent;
  int               cycle_count;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(11, 40);
  endfunction

  function automatic logic [PIX_W-1:0] rand_pixel(int mode);
    case (mode)
      0: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      1: return PIX_W'($urandom_range(0, 3));
      default: return PIX_W'($urandom_range(0, 255));
    endcase
  endfunction

  // result side: random backpressure, checked at the rising edge
  initial begin : result_ready
    int hold;
    out_ch.ready = 1'b0;
    hold = 0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        out_ch.ready <= 1'b0;
        hold--;
      end else begin
        out_ch.ready <= 1'b1;
        hold = pick_gap();
      end
    end
  end

  always @(posedge clk) begin : take_result
    result_t got;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got.row   = out_ch.best_row;
      got.col   = out_ch.best_col;
      got.score = out_ch.best_score;
      sb.check_result(got);
    end
  end

  // called at a falling edge, returns at the falling edge after the transaction
  task automatic send_pixel(func_t f, logic [PIX_W-1:0] p);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.func  <= f;
    in_ch.pixel <= p;
    do begin
      @(posedge clk);
    end while (!in_ch.ready);
    sb.note_input(f, p);
    pixels_sent++;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (sb.outstanding() != 0) @(negedge clk);
    repeat (16) @(negedge clk);
  endtask

  task automatic program_reg(reg_idx_t idx, int v);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= CFG_W'(v);
    sb.write_reg(idx, CFG_W'(v));
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_dims(int sr, int sc, int tr, int tc);
    wait_idle();
    program_reg(REG_SCENE_ROWS, sr);
    program_reg(REG_SCENE_COLS, sc);
    program_reg(REG_TPL_ROWS, tr);
    program_reg(REG_TPL_COLS, tc);
  endtask

  // one template load followed by one full scene, with occasional extra template pixels mixed in
  task automatic run_job(int mode);
    int unsigned sr, sc, tr, tc;
    int          need;
    int          ntpl;
    int          r;
    bit          fits;
    sb.used_dims(sr, sc, tr, tc);
    need    = tr * tc;
    fits    = (tr <= sr) && (tc <= sc);
    no_gaps = ($urandom_range(0, 3) == 0);
    r = $urandom_range(0, 9);
    if (!fits) begin
      ntpl = $urandom_range(0, 6);
      if (ntpl > need) ntpl = need;
    end else if (r < 6) begin
      ntpl = need;
    end else if (r < 8) begin
      ntpl = need + $urandom_range(1, 3);
    end else begin
      // partial reload only where older template data covers the rest
      ntpl = $urandom_range(0, need);
      for (int k = ntpl; k < need; k++) begin
        if (!tpl_loaded[k]) ntpl = need;
      end
    end
    for (int i = 0; i < ntpl; i++) begin
      send_pixel(FUNC_TPL, rand_pixel(mode));
      if (i < need) tpl_loaded[i] = 1'b1;
    end
    for (int s = 0; s < sr * sc; s++) begin
      if (ntpl >= need && $urandom_range(0, 19) == 0)
        send_pixel(FUNC_TPL, rand_pixel(2));
      send_pixel(FUNC_SCENE, rand_pixel(mode));
    end
  endtask

  function automatic int pick_scene_dim();
    if ($urandom_range(0, 19) == 0) return 0;
    return $urandom_range(1, 8);
  endfunction

  function automatic int pick_tpl_dim();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 0;
    if (r == 1) return $urandom_range(65, 127);
    return $urandom_range(1, 4);
  endfunction

  initial begin : stimulus
    sb           = new();
    rst          = 1'b1;
    cfg_we       = 1'b0;
    cfg_idx      = REG_SCENE_ROWS;
    cfg_data     = '0;
    in_ch.valid  = 1'b0;
    in_ch.func   = FUNC_TPL;
    in_ch.pixel  = '0;
    no_gaps      = 1'b0;
    pixels_sent  = 0;
    cycle_count  = 0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // 1x1 match, extra template pixel dropped, then no match at all
    set_dims(1, 1, 1, 1);
    send_pixel(FUNC_TPL, 8'hFF);
    send_pixel(FUNC_TPL, 8'h00);
    send_pixel(FUNC_SCENE, 8'hFF);
    tpl_loaded[0] = 1'b1;
    send_pixel(FUNC_TPL, 8'h00);
    send_pixel(FUNC_SCENE, 8'hFF);

    // zero sizes read as 1, oversized template clamps and cannot fit
    set_dims(0, 3, 0, 127);
    send_pixel(FUNC_SCENE, 8'h5A);
    send_pixel(FUNC_SCENE, 8'hA5);
    send_pixel(FUNC_SCENE, 8'h3C);

    // scene shrunk below the pixels already loaded
    set_dims(2, 2, 1, 1);
    send_pixel(FUNC_TPL, 8'd7);
    send_pixel(FUNC_SCENE, 8'd1);
    send_pixel(FUNC_SCENE, 8'd7);
    send_pixel(FUNC_SCENE, 8'd1);
    wait_idle();
    program_reg(REG_SCENE_ROWS, 1);
    send_pixel(FUNC_SCENE, 8'd9);

    // equal scores: first strictly higher one wins
    set_dims(2, 3, 1, 2);
    send_pixel(FUNC_TPL, 8'd5);
    send_pixel(FUNC_TPL, 8'd5);
    tpl_loaded[1] = 1'b1;
    send_pixel(FUNC_SCENE, 8'd5);
    send_pixel(FUNC_SCENE, 8'd0);
    send_pixel(FUNC_SCENE, 8'd5);
    send_pixel(FUNC_SCENE, 8'd5);
    send_pixel(FUNC_SCENE, 8'd5);
    send_pixel(FUNC_SCENE, 8'd0);

    // size extremes
    set_dims(70, 1, 127, 1);
    run_job($urandom_range(0, 2));
    set_dims(1, 70, 1, 64);
    run_job($urandom_range(0, 2));

    while (pixels_sent < 1100) begin
      set_dims(pick_scene_dim(), pick_scene_dim(), pick_tpl_dim(), pick_tpl_dim());
      repeat ($urandom_range(1, 4)) run_job($urandom_range(0, 2));
    end

    in_ch.valid <= 1'b0;
    while (sb.outstanding() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (sb.outstanding() != 0)
      $display("%0d expected results never arrived", sb.outstanding());
    if (sb.fails == 0 && sb.outstanding() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
